>>> src/t88_pkg.sv
// Shared types and constants for the taus88 bounded random generator.
// No dependencies; every other file in src/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package t88_pkg;

   localparam int WORD_W    = 32;
   localparam int BOUND_W   = 31;
   localparam int DIV_CNT_W = $clog2(WORD_W);

   localparam logic [WORD_W-1:0] WORD_ONES    = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd1;

   // Configuration register indexes
   localparam logic REG_SEED_FIRST  = 1'b0;
   localparam logic REG_SEED_SECOND = 1'b1;

   // Operations on the generator state bank
   typedef enum logic [2:0] {
      BANK_HOLD       = 3'd0,
      BANK_SEED_ONE   = 3'd1,
      BANK_SEED_TWO   = 3'd2,
      BANK_SEED_THREE = 3'd3,
      BANK_DRAW       = 3'd4
   } bank_op_type;

   // Start request to the shared divider
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

>>> src/t88_divider.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on t88_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module t88_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire t88_pkg::div_req_type      div_req,
   output logic                           div_done,
   output logic [t88_pkg::WORD_W-1:0]     div_quot
);

   logic                            busy_ff;
   logic                            done_ff;
   logic [t88_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [t88_pkg::WORD_W-1:0]      rem_ff;
   logic [t88_pkg::WORD_W-1:0]      quo_ff;
   logic [t88_pkg::WORD_W-1:0]      dsr_ff;

   logic [t88_pkg::WORD_W:0]        shifted;
   logic [t88_pkg::WORD_W:0]        diff;
   logic                            fits;

   // shift in the next dividend bit and try the subtraction
   assign shifted = {rem_ff, quo_ff[t88_pkg::WORD_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == t88_pkg::DIV_CNT_W'(t88_pkg::WORD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[t88_pkg::WORD_W-1:0] : shifted[t88_pkg::WORD_W-1:0];
         quo_ff <= {quo_ff[t88_pkg::WORD_W-2:0], fits};
      end
   end

   assign div_done = done_ff;
   assign div_quot = quo_ff;

endmodule

`default_nettype wire

>>> src/t88_bank.sv
// Generator state bank: three Tausworthe components per generator, LCG seeding
// and the draw step. Depends on t88_pkg for widths and bank operations.
`timescale 1ns / 1ps
`default_nettype none

module t88_bank #(
   parameter  int NUM_GENERATORS = 2,
   localparam int GEN_W          = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1
) (
   input  wire logic                      clock,
   input  wire t88_pkg::bank_op_type      bank_op,
   input  wire logic [GEN_W-1:0]          bank_gen,
   input  wire logic [t88_pkg::WORD_W-1:0] bank_seed,
   output logic [t88_pkg::WORD_W-1:0]     bank_word
);

   localparam logic [t88_pkg::WORD_W-1:0] LCG_MULT  = 32'd69069;
   localparam logic [t88_pkg::WORD_W-1:0] MIN_ONE   = 32'd2;
   localparam logic [t88_pkg::WORD_W-1:0] MIN_TWO   = 32'd8;
   localparam logic [t88_pkg::WORD_W-1:0] MIN_THREE = 32'd16;

   logic [t88_pkg::WORD_W-1:0] comp_one_ff   [NUM_GENERATORS];
   logic [t88_pkg::WORD_W-1:0] comp_two_ff   [NUM_GENERATORS];
   logic [t88_pkg::WORD_W-1:0] comp_three_ff [NUM_GENERATORS];
   logic [t88_pkg::WORD_W-1:0] word_ff;

   logic [t88_pkg::WORD_W-1:0] mul_src;
   logic [t88_pkg::WORD_W-1:0] mul_prod;
   logic [t88_pkg::WORD_W-1:0] nxt_one;
   logic [t88_pkg::WORD_W-1:0] nxt_two;
   logic [t88_pkg::WORD_W-1:0] nxt_three;

   function automatic logic [t88_pkg::WORD_W-1:0] step_one(input logic [t88_pkg::WORD_W-1:0] a);
      logic [t88_pkg::WORD_W-1:0] hi;
      logic [t88_pkg::WORD_W-1:0] lo;
      hi = (a & 32'hFFFF_FFFE) << 12;
      lo = ((a << 13) ^ a) >> 19;
      return hi ^ lo;
   endfunction

   function automatic logic [t88_pkg::WORD_W-1:0] step_two(input logic [t88_pkg::WORD_W-1:0] b);
      logic [t88_pkg::WORD_W-1:0] hi;
      logic [t88_pkg::WORD_W-1:0] lo;
      hi = (b & 32'hFFFF_FFF8) << 4;
      lo = ((b << 2) ^ b) >> 25;
      return hi ^ lo;
   endfunction

   function automatic logic [t88_pkg::WORD_W-1:0] step_three(input logic [t88_pkg::WORD_W-1:0] c);
      logic [t88_pkg::WORD_W-1:0] hi;
      logic [t88_pkg::WORD_W-1:0] lo;
      hi = (c & 32'hFFFF_FFF0) << 17;
      lo = ((c << 3) ^ c) >> 11;
      return hi ^ lo;
   endfunction

   // one shared LCG multiplier walks the seeding chain
   always_comb begin
      case (bank_op)
         t88_pkg::BANK_SEED_ONE:   mul_src = bank_seed;
         t88_pkg::BANK_SEED_TWO:   mul_src = comp_one_ff[bank_gen];
         t88_pkg::BANK_SEED_THREE: mul_src = comp_two_ff[bank_gen];
         default:                  mul_src = '0;
      endcase
   end

   assign mul_prod  = t88_pkg::WORD_W'(mul_src * LCG_MULT);
   assign nxt_one   = step_one(comp_one_ff[bank_gen]);
   assign nxt_two   = step_two(comp_two_ff[bank_gen]);
   assign nxt_three = step_three(comp_three_ff[bank_gen]);

   always_ff @(posedge clock) begin
      case (bank_op)
         t88_pkg::BANK_SEED_ONE: begin
            comp_one_ff[bank_gen] <= (mul_prod < MIN_ONE) ? mul_prod + MIN_ONE : mul_prod;
         end
         t88_pkg::BANK_SEED_TWO: begin
            comp_two_ff[bank_gen] <= (mul_prod < MIN_TWO) ? mul_prod + MIN_TWO : mul_prod;
         end
         t88_pkg::BANK_SEED_THREE: begin
            comp_three_ff[bank_gen] <= (mul_prod < MIN_THREE) ? mul_prod + MIN_THREE
                                                              : mul_prod;
         end
         t88_pkg::BANK_DRAW: begin
            comp_one_ff[bank_gen]   <= nxt_one;
            comp_two_ff[bank_gen]   <= nxt_two;
            comp_three_ff[bank_gen] <= nxt_three;
            word_ff                 <= nxt_one ^ nxt_two ^ nxt_three;
         end
         default: begin
         end
      endcase
   end

   assign bank_word = word_ff;

endmodule

`default_nettype wire

>>> src/taus88_bounded_random_generator.sv
// Top level of the taus88 bounded random generator: sequencer, output register.
// Depends on t88_pkg, t88_bank and t88_divider.
`timescale 1ns / 1ps
`default_nettype none

// Holds NUM_GENERATORS independent combined Tausworthe (taus88) streams. A request
// beat names a stream (tuser) and an exclusive bound (tdata); bound zero returns
// the raw 32-bit word, any other bound a uniform integer below it, drawn as
// word / (0xFFFFFFFF / bound) with redraw while the quotient reaches the bound.
// One request is worked on at a time and req_tready is low meanwhile. All
// division runs through one shared divider that yields one quotient bit per
// cycle. The result waits in an output register, so the next request may be
// accepted while it is held. After reset the block seeds every stream with 1
// and warms it by WARMUP_STEPS discarded draws before it takes any beat. A
// seed write on the csr channel reseeds its stream the same way (zero acts as
// one); csr_ready and req_tready stay low until that finishes.
module taus88_bounded_random_generator #(
   parameter int NUM_GENERATORS = 2,
   parameter int WARMUP_STEPS   = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [30:0] bound, [31] zero
   input  wire logic        req_tuser,   // [0] generator
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] value
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int GEN_W  = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
   localparam int WARM_W = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;
   localparam logic [GEN_W-1:0]  LAST_GEN  = GEN_W'(NUM_GENERATORS - 1);
   localparam logic [WARM_W-1:0] LAST_WARM = WARM_W'(WARMUP_STEPS - 1);

   typedef enum logic [9:0] {
      S_SEED_ONE   = 10'b00_0000_0001,
      S_SEED_TWO   = 10'b00_0000_0010,
      S_SEED_THREE = 10'b00_0000_0100,
      S_WARM       = 10'b00_0000_1000,
      S_IDLE       = 10'b00_0001_0000,
      S_SCALE      = 10'b00_0010_0000,
      S_DRAW       = 10'b00_0100_0000,
      S_FETCH      = 10'b00_1000_0000,
      S_DIVIDE     = 10'b01_0000_0000,
      S_OUT        = 10'b10_0000_0000
   } state_type;

   state_type                        state_ff, state_in;
   logic                             sweep_ff, sweep_in;
   logic [GEN_W-1:0]                 gen_ff, gen_in;
   logic [t88_pkg::WORD_W-1:0]       seed_ff, seed_in;
   logic [WARM_W-1:0]                warm_ff, warm_in;
   logic [t88_pkg::BOUND_W-1:0]      bound_ff, bound_in;
   logic [t88_pkg::WORD_W-1:0]       scale_ff, scale_in;
   logic [t88_pkg::WORD_W-1:0]       result_ff, result_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [t88_pkg::WORD_W-1:0]       rsp_value_ff, rsp_value_in;

   t88_pkg::bank_op_type             bank_op;
   logic [t88_pkg::WORD_W-1:0]       bank_word;
   t88_pkg::div_req_type             div_req;
   logic                             div_done;
   logic [t88_pkg::WORD_W-1:0]       div_quot;

   logic                             seed_done;
   logic [GEN_W-1:0]                 req_gen;
   logic [t88_pkg::BOUND_W-1:0]      req_bound;

   t88_bank #(
      .NUM_GENERATORS (NUM_GENERATORS)
   ) u_bank (
      .clock     (clock),
      .bank_op   (bank_op),
      .bank_gen  (gen_ff),
      .bank_seed (seed_ff),
      .bank_word (bank_word)
   );

   t88_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   // a single stream wraps every selector onto stream zero
   assign req_gen   = (NUM_GENERATORS > 1) ? GEN_W'(req_tuser) : '0;
   assign req_bound = req_tdata[t88_pkg::BOUND_W-1:0];

   // csr writes win over requests in the same idle cycle
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      gen_in       = gen_ff;
      seed_in      = seed_ff;
      warm_in      = warm_ff;
      bound_in     = bound_ff;
      scale_in     = scale_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      bank_op      = t88_pkg::BANK_HOLD;
      div_req      = '0;
      seed_done    = 1'b0;

      case (state_ff)
         S_SEED_ONE: begin
            bank_op  = t88_pkg::BANK_SEED_ONE;
            state_in = S_SEED_TWO;
         end
         S_SEED_TWO: begin
            bank_op  = t88_pkg::BANK_SEED_TWO;
            state_in = S_SEED_THREE;
         end
         S_SEED_THREE: begin
            bank_op = t88_pkg::BANK_SEED_THREE;
            warm_in = '0;
            if (WARMUP_STEPS == 0) begin
               seed_done = 1'b1;
            end else begin
               state_in = S_WARM;
            end
         end
         S_WARM: begin
            // discard the warm-up words
            bank_op = t88_pkg::BANK_DRAW;
            warm_in = warm_ff + 1'b1;
            if (warm_ff == LAST_WARM) begin
               seed_done = 1'b1;
            end
         end
         S_IDLE: begin
            if (csr_valid) begin
               // a write for a stream that does not exist is dropped
               if (csr_index == t88_pkg::REG_SEED_FIRST || NUM_GENERATORS > 1) begin
                  gen_in   = (csr_index == t88_pkg::REG_SEED_FIRST) ? '0 : GEN_W'(1);
                  seed_in  = (csr_data == '0) ? t88_pkg::SEED_DEFAULT : csr_data;
                  state_in = S_SEED_ONE;
               end
            end else if (req_tvalid) begin
               gen_in   = req_gen;
               bound_in = req_bound;
               if (req_bound == '0) begin
                  state_in = S_DRAW;
               end else begin
                  // scale = 0xFFFFFFFF / bound, once per request
                  div_req.start    = 1'b1;
                  div_req.dividend = t88_pkg::WORD_ONES;
                  div_req.divisor  = {1'b0, req_bound};
                  state_in         = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            if (div_done) begin
               scale_in = div_quot;
               state_in = S_DRAW;
            end
         end
         S_DRAW: begin
            bank_op  = t88_pkg::BANK_DRAW;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            if (bound_ff == '0) begin
               result_in = bank_word;
               state_in  = S_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = bank_word;
               div_req.divisor  = scale_ff;
               state_in         = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               // reject quotients at or above the bound and draw again
               if (div_quot < {1'b0, bound_ff}) begin
                  result_in = div_quot;
                  state_in  = S_OUT;
               end else begin
                  state_in = S_DRAW;
               end
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // after reset, walk every stream in turn; otherwise return to idle
      if (seed_done) begin
         if (sweep_ff && gen_ff != LAST_GEN) begin
            gen_in   = gen_ff + 1'b1;
            state_in = S_SEED_ONE;
         end else begin
            sweep_in = 1'b0;
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SEED_ONE;
         sweep_ff     <= 1'b1;
         gen_ff       <= '0;
         seed_ff      <= t88_pkg::SEED_DEFAULT;
         warm_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         gen_ff       <= gen_in;
         seed_ff      <= seed_in;
         warm_ff      <= warm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bound_ff     <= bound_in;
      scale_ff     <= scale_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for taus88_bounded_random_generator: a directed table, then seeded
// random phases, all checked beat by beat against an in-bench model of both streams.
// Depends on t88_pkg and the RTL under src/.

module tb_top;

   localparam int STREAMS = 2;
   localparam int WARMUP  = 6;
   localparam int WORD_W  = t88_pkg::WORD_W;
   localparam int BOUND_W = t88_pkg::BOUND_W;

   // one row of the directed table; known rows carry a value typed in by hand
   typedef struct {
      logic               stream;
      logic [BOUND_W-1:0] bound;
      bit                 known;
      logic [WORD_W-1:0]  value;
   } probe_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;    // [30:0] bound, [31] zero
   logic              req_tuser;    // [0] generator
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;    // [31:0] value
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_index;
   logic [31:0]       csr_data;

   // model state: three Tausworthe components per stream, plus the seed registers
   logic [WORD_W-1:0] lane_one   [STREAMS];
   logic [WORD_W-1:0] lane_two   [STREAMS];
   logic [WORD_W-1:0] lane_three [STREAMS];
   logic [WORD_W-1:0] seed_copy  [STREAMS];

   logic [WORD_W-1:0] pending_values [$];   // values still owed by the block, oldest first
   int                fault_count = 0;
   bit                calm        = 1'b0;   // suppress random gaps on both sides
   bit                hold_long   = 1'b0;   // ask the result side for one long stall

   probe_row_type probe_rows [18] = '{
      '{1'b0, 31'd0,           1'b0, 32'd0},   // raw word straight after reset
      '{1'b1, 31'd0,           1'b0, 32'd0},
      '{1'b0, 31'd1,           1'b1, 32'd0},   // bound one can only give zero
      '{1'b1, 31'd1,           1'b1, 32'd0},
      '{1'b0, 31'h7FFF_FFFF,   1'b0, 32'd0},   // widest bound
      '{1'b1, 31'h7FFF_FFFF,   1'b0, 32'd0},
      '{1'b0, 31'd2,           1'b0, 32'd0},
      '{1'b1, 31'd2,           1'b0, 32'd0},
      '{1'b0, 31'h4000_0001,   1'b0, 32'd0},   // scale 3: about a quarter of draws rejected
      '{1'b1, 31'h4000_0001,   1'b0, 32'd0},
      '{1'b0, 31'h2AAA_AAAB,   1'b0, 32'd0},
      '{1'b1, 31'd3,           1'b0, 32'd0},
      '{1'b0, 31'h7FFF_FFFE,   1'b0, 32'd0},
      '{1'b1, 31'h0001_0000,   1'b0, 32'd0},
      '{1'b0, 31'd1,           1'b1, 32'd0},
      '{1'b1, 31'd1,           1'b1, 32'd0},
      '{1'b1, 31'd0,           1'b0, 32'd0},
      '{1'b0, 31'h5555_5555,   1'b0, 32'd0}
   };

   taus88_bounded_random_generator #(
      .NUM_GENERATORS (STREAMS),
      .WARMUP_STEPS   (WARMUP)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #12_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // advance one stream by a full combined step and return the XOR word
   function automatic logic [WORD_W-1:0] step_stream(int g);
      logic [WORD_W-1:0] a, b, c;
      a = lane_one[g];
      b = lane_two[g];
      c = lane_three[g];
      a = ((a & 32'hFFFF_FFFE) << 12) ^ (((a << 13) ^ a) >> 19);
      b = ((b & 32'hFFFF_FFF8) << 4)  ^ (((b << 2) ^ b) >> 25);
      c = ((c & 32'hFFFF_FFF0) << 17) ^ (((c << 3) ^ c) >> 11);
      lane_one[g]   = a;
      lane_two[g]   = b;
      lane_three[g] = c;
      return a ^ b ^ c;
   endfunction

   // LCG chain with the component minimums, then the discarded warm-up draws
   function automatic void seed_stream(int g, logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] x;
      x = (s == '0) ? t88_pkg::SEED_DEFAULT : s;
      lane_one[g] = x * 32'd69069;
      if (lane_one[g] < 32'd2) lane_one[g] += 32'd2;
      lane_two[g] = lane_one[g] * 32'd69069;
      if (lane_two[g] < 32'd8) lane_two[g] += 32'd8;
      lane_three[g] = lane_two[g] * 32'd69069;
      if (lane_three[g] < 32'd16) lane_three[g] += 32'd16;
      repeat (WARMUP) void'(step_stream(g));
   endfunction

   // expected value of one request: raw word, or scaled draw with redraw
   function automatic logic [WORD_W-1:0] predict_draw(int g, logic [BOUND_W-1:0] bound);
      logic [WORD_W-1:0] scale, v;
      if (bound == '0) return step_stream(g);
      scale = t88_pkg::WORD_ONES / {1'b0, bound};
      do
         v = step_stream(g) / scale;
      while (v >= {1'b0, bound});
      return v;
   endfunction

   function automatic void report_fault(string what, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
      if (fault_count < 10)
         $display("%0t ns: %s: expected %08h, got %08h", $realtime, what, want, got);
      fault_count++;
   endfunction

   // offer one request beat; keep tvalid high into the next item when no gap is drawn
   task automatic send_request(input logic s, input logic [BOUND_W-1:0] b,
                               input bit known, input logic [WORD_W-1:0] v);
      int                gap;
      logic [WORD_W-1:0] want;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, b};
      req_tuser  <= s;
      do @(posedge clock); while (req_tready !== 1'b1);
      want = predict_draw(s, b);
      pending_values.push_back(known ? want & '0 | v : want);
   endtask

   // write both seed registers back to back; each write reseeds its stream
   task automatic load_seeds(input logic [WORD_W-1:0] first, input logic [WORD_W-1:0] second);
      logic [WORD_W-1:0] word;
      logic              idx;
      for (int k = 0; k < STREAMS; k++) begin
         idx  = (k == 0) ? t88_pkg::REG_SEED_FIRST : t88_pkg::REG_SEED_SECOND;
         word = (k == 0) ? first : second;
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= word;
         do @(posedge clock); while (csr_ready !== 1'b1);
         seed_copy[idx] = word;
         seed_stream(idx, word);
      end
      csr_valid <= 1'b0;
   endtask

   // result side: random stalls per beat, one long stall on request, compare in order
   initial begin : result_sink
      int                gap;
      int                held;
      logic [WORD_W-1:0] want;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_long) begin
            // stall long enough for the block to fill its output register and back up
            hold_long = 1'b0;
            rsp_tready <= 1'b0;
            held = 0;
            while (held < 300) begin
               @(posedge clock);
               held++;
            end
         end
         gap = calm ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (pending_values.size() == 0) begin
            report_fault("result beat with nothing outstanding", '0, rsp_tdata);
         end else begin
            want = pending_values.pop_front();
            if (rsp_tdata !== want) report_fault("value mismatch", want, rsp_tdata);
         end
      end
   end

   initial begin : stimulus
      logic [WORD_W-1:0]  inv;
      logic [WORD_W-1:0]  seed_zero [6];
      logic [WORD_W-1:0]  seed_one  [6];
      logic               s;
      logic [BOUND_W-1:0] b;
      int                 pick;
      int                 drain;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= t88_pkg::REG_SEED_FIRST;
      csr_data   <= '0;

      // inverse of the LCG multiplier: seeds built from it drive each component
      // product to 1, so the raise-to-minimum paths get exercised
      inv = 32'd69069;
      repeat (5) inv = inv * (32'd2 - 32'd69069 * inv);
      seed_zero[0] = 32'd0;              seed_one[0] = 32'hFFFF_FFFF;
      seed_zero[1] = inv * inv;          seed_one[1] = inv;
      seed_zero[2] = $urandom;           seed_one[2] = $urandom;
      seed_zero[3] = 32'hFFFF_FFFF;      seed_one[3] = 32'd0;
      seed_zero[4] = inv * inv * inv;    seed_one[4] = $urandom;
      seed_zero[5] = $urandom;           seed_one[5] = 32'h8000_0000;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int g = 0; g < STREAMS; g++) begin
         seed_copy[g] = t88_pkg::SEED_DEFAULT;
         seed_stream(g, t88_pkg::SEED_DEFAULT);
      end

      // directed table on the reset seeds
      foreach (probe_rows[i])
         send_request(probe_rows[i].stream, probe_rows[i].bound,
                      probe_rows[i].known, probe_rows[i].value);

      // random phases, each on a fresh pair of seeds
      for (int phase = 0; phase < 6; phase++) begin
         req_tvalid <= 1'b0;
         // drain: seeds may only change while the block is idle
         while (pending_values.size() != 0) @(posedge clock);
         load_seeds(seed_zero[phase], seed_one[phase]);
         calm = (phase == 2);
         if (phase == 1) hold_long = 1'b1;
         repeat (150) begin
            s    = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 7);
            case (pick)
               0: begin
                  b = '0;
               end
               1: begin
                  b = BOUND_W'($urandom_range(1, 16));
               end
               default: begin
                  b = BOUND_W'($urandom >> $urandom_range(1, 31));
               end
            endcase
            send_request(s, b, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;

      // wait out the last results, then watch for stray beats
      drain = 0;
      while (pending_values.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (200) @(posedge clock);
      if (pending_values.size() != 0) begin
         $display("%0d expected results never arrived", pending_values.size());
         fault_count += pending_values.size();
      end

      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
